/* sv/vda_pkg.sv */
// Shared constants, types and the arctangent table for the vector direction angle block.
// Used by vda_cordic and vector_direction_angle_top. No dependencies.
package vda_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;
	localparam int ANGLE_WIDTH = 9 + FRAC_BITS;

	// CORDIC working formats: x/y carry the delta magnitudes shifted up, z is in 2^-ZFRAC degree
	localparam int ZFRAC    = 20;
	localparam int XY_SHIFT = 24;
	localparam int NITER    = 20;
	localparam int XY_WIDTH = COORD_WIDTH + XY_SHIFT + 3;
	localparam int Z_WIDTH  = ZFRAC + 9;
	localparam int RND_SH   = ZFRAC - FRAC_BITS;

	localparam logic signed [Z_WIDTH-1:0] Z_MAX = Z_WIDTH'(90 * (64'd1 << ZFRAC));
	localparam logic [Z_WIDTH-1:0] Z_HALF = Z_WIDTH'(64'd1 << (RND_SH - 1));

	localparam logic [ANGLE_WIDTH-1:0] ANG_90   = ANGLE_WIDTH'(90 * (64'd1 << FRAC_BITS));
	localparam logic [ANGLE_WIDTH-1:0] ANG_180  = ANGLE_WIDTH'(180 * (64'd1 << FRAC_BITS));
	localparam logic [ANGLE_WIDTH-1:0] ANG_270  = ANGLE_WIDTH'(270 * (64'd1 << FRAC_BITS));
	localparam logic [ANGLE_WIDTH-1:0] ANG_FULL = ANGLE_WIDTH'(360 * (64'd1 << FRAC_BITS));

	// round(atan(2^-i) in degrees * 2^20)
	localparam logic signed [Z_WIDTH-1:0] ATAN_TAB [NITER] = '{
		Z_WIDTH'(47185920), Z_WIDTH'(27855475), Z_WIDTH'(14718068), Z_WIDTH'(7471121),
		Z_WIDTH'(3750058),  Z_WIDTH'(1876857),  Z_WIDTH'(938658),   Z_WIDTH'(469357),
		Z_WIDTH'(234682),   Z_WIDTH'(117342),   Z_WIDTH'(58671),    Z_WIDTH'(29335),
		Z_WIDTH'(14668),    Z_WIDTH'(7334),     Z_WIDTH'(3667),     Z_WIDTH'(1833),
		Z_WIDTH'(917),      Z_WIDTH'(458),      Z_WIDTH'(229),      Z_WIDTH'(115)
	};

	// Per-item sideband that rides along the arctangent pipeline
	typedef struct packed {
		logic                   special;
		logic [ANGLE_WIDTH-1:0] special_val;
		logic                   dx_neg;
		logic                   dy_neg;
	} side_t;

endpackage

/* sv/vda_cordic.sv */
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
// Depends on vda_pkg (widths, ATAN_TAB, side_t).
module vda_cordic import vda_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [XY_WIDTH-1:0] x,
	input  logic signed [XY_WIDTH-1:0] y,
	input  side_t                      side,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [Z_WIDTH-1:0]  z,
	output side_t                      out_side
);

	logic                       v_s    [NITER];
	logic signed [XY_WIDTH-1:0] x_s    [NITER];
	logic signed [XY_WIDTH-1:0] y_s    [NITER];
	logic signed [Z_WIDTH-1:0]  z_s    [NITER];
	side_t                      side_s [NITER];
	logic [NITER-1:0]           rdy;

	for (genvar k = 0; k < NITER; k++) begin : g_stage
		logic                       vp;
		logic signed [XY_WIDTH-1:0] xp, yp, xsh, ysh, xn, yn;
		logic signed [Z_WIDTH-1:0]  zp, zn;
		side_t                      sp;

		if (k == 0) begin : g_first
			assign vp = in_valid;
			assign xp = x;
			assign yp = y;
			assign zp = '0;
			assign sp = side;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign xp = x_s[k-1];
			assign yp = y_s[k-1];
			assign zp = z_s[k-1];
			assign sp = side_s[k-1];
		end

		// a stage takes new data when empty or when its successor moves
		if (k == NITER - 1) begin : g_rdy_last
			assign rdy[k] = !v_s[k] || !out_stall;
		end else begin : g_rdy
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end

		assign xsh = xp >>> k;
		assign ysh = yp >>> k;

		always_comb begin
			if (!yp[XY_WIDTH-1]) begin
				xn = xp + ysh;
				yn = yp - xsh;
				zn = zp + ATAN_TAB[k];
			end else begin
				xn = xp - ysh;
				yn = yp + xsh;
				zn = zp - ATAN_TAB[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				x_s[k]    <= xn;
				y_s[k]    <= yn;
				z_s[k]    <= zn;
				side_s[k] <= sp;
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_s[NITER-1];
	assign z         = z_s[NITER-1];
	assign out_side  = side_s[NITER-1];

endmodule

/* sv/vector_direction_angle_top.sv */
// Top level of the vector direction angle block: front end, CORDIC pipeline, quadrant mapping.
// Depends on vda_pkg and vda_cordic.

// Gives the direction from (first_x, first_y) to (second_x, second_y) in degrees,
// counterclockwise from the +x axis with screen y flipped so that up is 90, as an unsigned
// value with FRAC_BITS fraction bits in 0 up to just below 360. One item is taken per cycle
// while pt_stall is low. The pipeline has one stage for the deltas, twenty for the
// unrolled CORDIC micro-rotations, one for clamp and rounding, one for quadrant mapping into
// the output register. Every stage has its own valid bit and moves on its own, so bubbles
// are squeezed out, and while angle_stall holds a result, new items enter until all stages are full.
module vector_direction_angle_top import vda_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pt_valid,
	output logic                          pt_stall,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	output logic                          angle_valid,
	input  logic                          angle_stall,
	output logic [ANGLE_WIDTH-1:0]        angle_deg
);

	// ---- stage 1: deltas, magnitudes, axis cases
	logic signed [COORD_WIDTH:0] dx, dy;
	logic [COORD_WIDTH:0]        adx, ady;
	side_t                       side_d;

	logic                   v_s1;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1;
	side_t                  side_s1;
	logic                   rdy_s1;

	logic                       cd_in_stall, cd_out_valid, cd_out_stall;
	logic signed [XY_WIDTH-1:0] cd_x, cd_y;
	logic signed [Z_WIDTH-1:0]  cd_z;
	side_t                      cd_side;

	assign dx  = $signed({second_x[COORD_WIDTH-1], second_x})
	           - $signed({first_x[COORD_WIDTH-1], first_x});
	assign dy  = $signed({first_y[COORD_WIDTH-1], first_y})
	           - $signed({second_y[COORD_WIDTH-1], second_y});
	assign adx = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
	assign ady = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;

	always_comb begin
		side_d.dx_neg      = dx[COORD_WIDTH];
		side_d.dy_neg      = dy[COORD_WIDTH];
		side_d.special     = (dx == '0) || (dy == '0);
		priority if (dx == '0 && dy == '0) begin
			side_d.special_val = '0;
		end else if (dx == '0) begin
			side_d.special_val = dy[COORD_WIDTH] ? ANG_270 : ANG_90;
		end else if (dx[COORD_WIDTH]) begin
			side_d.special_val = ANG_180;
		end else begin
			side_d.special_val = '0;
		end
	end

	assign rdy_s1   = !v_s1 || !cd_in_stall;
	assign pt_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= pt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ax_s1   <= adx[COORD_WIDTH-1:0];
			ay_s1   <= ady[COORD_WIDTH-1:0];
			side_s1 <= side_d;
		end
	end

	// ---- stages 2..21: arctangent of the magnitudes
	assign cd_x = $signed(XY_WIDTH'({ax_s1, {XY_SHIFT{1'b0}}}));
	assign cd_y = $signed(XY_WIDTH'({ay_s1, {XY_SHIFT{1'b0}}}));

	vda_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_stall  (cd_in_stall),
		.x         (cd_x),
		.y         (cd_y),
		.side      (side_s1),
		.out_valid (cd_out_valid),
		.out_stall (cd_out_stall),
		.z         (cd_z),
		.out_side  (cd_side)
	);

	// ---- stage 22: clamp to 0..90 and round to output precision
	logic signed [Z_WIDTH-1:0] zc;
	logic [Z_WIDTH-1:0]        zr;
	logic                      v_s22;
	logic [ANGLE_WIDTH-1:0]    q_s22;
	side_t                     side_s22;
	logic                      rdy_s22, rdy_s23;

	always_comb begin
		priority if (cd_z[Z_WIDTH-1]) begin
			zc = '0;
		end else if (cd_z > Z_MAX) begin
			zc = Z_MAX;
		end else begin
			zc = cd_z;
		end
	end

	assign zr = $unsigned(zc) + Z_HALF;

	assign rdy_s23      = !angle_valid || !angle_stall;
	assign rdy_s22      = !v_s22 || rdy_s23;
	assign cd_out_stall = !rdy_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else if (rdy_s22) begin
			v_s22 <= cd_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s22) begin
			q_s22    <= zr[Z_WIDTH-1 -: ANGLE_WIDTH];
			side_s22 <= cd_side;
		end
	end

	// ---- stage 23: quadrant mapping, wrap, output register
	logic [ANGLE_WIDTH-1:0] mapped, wrapped, res;

	always_comb begin
		unique case ({side_s22.dx_neg, side_s22.dy_neg})
			2'b00:   mapped = q_s22;
			2'b10:   mapped = ANG_180 - q_s22;
			2'b11:   mapped = ANG_180 + q_s22;
			default: mapped = ANG_FULL - q_s22;
		endcase
		wrapped = (mapped >= ANG_FULL) ? (mapped - ANG_FULL) : mapped;
		res     = side_s22.special ? side_s22.special_val : wrapped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_valid <= 1'b0;
		end else if (rdy_s23) begin
			angle_valid <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s23) begin
			angle_deg <= res;
		end
	end

`ifndef SYNTH
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_valid |-> (angle_deg < ANG_FULL))
		else $error("angle out of range");

	a_q_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		v_s22 |-> (q_s22 <= ANG_90))
		else $error("first-quadrant angle above 90 degrees");

	a_front_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !pt_stall)
		else $error("input stalled with an empty front stage");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(angle_valid && angle_stall) |=> (angle_valid && $stable(angle_deg)))
		else $error("held result changed");
`endif

endmodule
